>>> rtl/pba_pkg.sv
package pba_pkg;

  localparam int MaxPages = 1024;
  localparam int WordW    = 32;
  localparam int BitW     = $clog2(WordW);
  localparam int NumWords = (MaxPages + WordW - 1) / WordW;
  localparam int WordIdxW = $clog2(NumWords);
  localparam int CntW     = WordIdxW + 1;
  localparam int PopW     = $clog2(WordW + 1);
  localparam int RangeW   = 11;
  localparam int PageW    = 10;
  localparam int CountW   = 11;
  localparam int AddrW    = 3;
  localparam int DataW    = 32;

  localparam logic [RangeW-1:0] RangeReset = 11'd1024;

  localparam logic [1:0] KindQuery = 2'd0;
  localparam logic [1:0] KindMark  = 2'd1;
  localparam logic [1:0] KindFree  = 2'd2;

  localparam logic [1:0] ErrOk    = 2'd0;
  localparam logic [1:0] ErrUsed  = 2'd1;
  localparam logic [1:0] ErrFree  = 2'd2;
  localparam logic [1:0] ErrRange = 2'd3;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_MODIFY,
    ST_FIND,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic [1:0]       kind;
    logic [PageW-1:0] page_index;
  } pba_in_t;

  typedef struct packed {
    logic              was_used;
    logic [1:0]        error_code;
    logic [CountW-1:0] free_count;
    logic              any_free;
    logic [PageW-1:0]  lowest_free_page;
  } pba_out_t;

  typedef struct packed {
    logic                re;
    logic [WordIdxW-1:0] raddr;
    logic                we;
    logic [WordIdxW-1:0] waddr;
    logic [WordW-1:0]    wdata;
  } pba_mem_req_t;

  // Bits of word w that lie below the page limit.
  function automatic logic [WordW-1:0] word_mask(logic [WordIdxW-1:0] w,
                                                 logic [RangeW-1:0] lim);
    logic [WordW-1:0] m;
    m = '0;
    for (int b = 0; b < WordW; b++) begin
      m[b] = (32'({w, BitW'(b)}) < 32'(lim));
    end
    return m;
  endfunction

  function automatic logic [PopW-1:0] popcnt(logic [WordW-1:0] v);
    logic [PopW-1:0] n;
    n = '0;
    for (int b = 0; b < WordW; b++) begin
      n = n + PopW'(v[b]);
    end
    return n;
  endfunction

  function automatic logic [WordIdxW-1:0] lowest_word(logic [NumWords-1:0] v);
    logic [WordIdxW-1:0] idx;
    idx = '0;
    for (int i = NumWords - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = WordIdxW'(i);
      end
    end
    return idx;
  endfunction

  function automatic logic [BitW-1:0] lowest_bit(logic [WordW-1:0] v);
    logic [BitW-1:0] idx;
    idx = '0;
    for (int i = WordW - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = BitW'(i);
      end
    end
    return idx;
  endfunction

endpackage

>>> rtl/pba_bitmap_ram.sv
module pba_bitmap_ram (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pba_pkg::pba_mem_req_t req_i,
  output logic [pba_pkg::WordW-1:0] rdata_o
);
  import pba_pkg::*;

  logic [WordW-1:0]    mem_q [NumWords];
  logic [NumWords-1:0] row_vld_q;
  logic [WordW-1:0]    rd_data_q;
  logic                rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rd_data_q <= mem_q[req_i.raddr];
    end
  end

  // A row never written reads as all free.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (req_i.we) begin
        row_vld_q[req_i.waddr] <= 1'b1;
      end
      if (req_i.re) begin
        rd_vld_q <= row_vld_q[req_i.raddr];
      end
    end
  end

  assign rdata_o = rd_vld_q ? rd_data_q : '0;

endmodule

>>> rtl/pba_ctrl.sv
module pba_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  pba_pkg::pba_in_t            in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output pba_pkg::pba_out_t           out_data_o,
  input  logic [pba_pkg::RangeW-1:0]  lim_i,
  input  logic                        cfg_we_i,
  output pba_pkg::pba_mem_req_t       mem_req_o,
  input  logic [pba_pkg::WordW-1:0]   mem_rdata_i
);
  import pba_pkg::*;

  state_e              state_q, state_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                proc_vld_q, proc_vld_d;
  logic [WordIdxW-1:0] proc_word_q, proc_word_d;
  logic [CountW-1:0]   used_q, used_d;
  logic [NumWords-1:0] avail_q, avail_d;
  logic [1:0]          kind_q, kind_d;
  logic [PageW-1:0]    page_q, page_d;
  logic                was_q, was_d;
  logic [1:0]          err_q, err_d;
  logic [WordIdxW-1:0] find_word_q, find_word_d;
  logic                found_q, found_d;
  logic                out_vld_q, out_vld_d;
  pba_out_t            out_q, out_d;

  logic [WordIdxW-1:0] word_sel;
  logic [BitW-1:0]     bit_sel;
  logic [WordW-1:0]    mask;
  logic [WordW-1:0]    new_word;
  logic                sweep_done;
  logic                out_free;

  assign word_sel   = page_q[BitW +: WordIdxW];
  assign bit_sel    = page_q[BitW-1:0];
  assign sweep_done = (cnt_q == CntW'(NumWords)) && !proc_vld_q;
  assign out_free   = !out_vld_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_SWEEP:  if (sweep_done) state_d = ST_IDLE;
      ST_IDLE:   if (in_valid_i) state_d = ST_MODIFY;
      ST_MODIFY: state_d = ST_FIND;
      ST_FIND:   state_d = ST_RESULT;
      ST_RESULT: if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_SWEEP;
    endcase
    if (cfg_we_i) begin
      state_d = ST_SWEEP;
    end
  end

  always_comb begin
    cnt_d       = cnt_q;
    proc_vld_d  = proc_vld_q;
    proc_word_d = proc_word_q;
    used_d      = used_q;
    avail_d     = avail_q;
    kind_d      = kind_q;
    page_d      = page_q;
    was_d       = was_q;
    err_d       = err_q;
    find_word_d = find_word_q;
    found_d     = found_q;
    out_vld_d   = out_vld_q;
    out_d       = out_q;
    mem_req_o   = '0;
    mask        = '0;
    new_word    = mem_rdata_i;

    if (out_vld_q && out_ready_i) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      ST_SWEEP: begin
        if (cnt_q != CntW'(NumWords)) begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = cnt_q[WordIdxW-1:0];
          cnt_d           = cnt_q + 1'b1;
          proc_vld_d      = 1'b1;
          proc_word_d     = cnt_q[WordIdxW-1:0];
        end else begin
          proc_vld_d = 1'b0;
        end
        if (proc_vld_q) begin
          mask                 = word_mask(proc_word_q, lim_i);
          used_d               = used_q + CountW'(popcnt(mem_rdata_i & mask));
          avail_d[proc_word_q] = |(~mem_rdata_i & mask);
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = in_data_i.page_index[BitW +: WordIdxW];
          kind_d          = in_data_i.kind;
          page_d          = in_data_i.page_index;
        end
      end
      ST_MODIFY: begin
        mask  = word_mask(word_sel, lim_i);
        was_d = mem_rdata_i[bit_sel];
        err_d = ErrOk;
        if (RangeW'(page_q) >= lim_i) begin
          was_d = 1'b0;
          err_d = ErrRange;
        end else begin
          case (kind_q)
            KindMark: begin
              if (mem_rdata_i[bit_sel]) begin
                err_d = ErrUsed;
              end else begin
                new_word          = mem_rdata_i | (WordW'(1) << bit_sel);
                mem_req_o.we      = 1'b1;
                mem_req_o.waddr   = word_sel;
                mem_req_o.wdata   = new_word;
                used_d            = used_q + 1'b1;
                avail_d[word_sel] = |(~new_word & mask);
              end
            end
            KindFree: begin
              if (!mem_rdata_i[bit_sel]) begin
                err_d = ErrFree;
              end else begin
                new_word          = mem_rdata_i & ~(WordW'(1) << bit_sel);
                mem_req_o.we      = 1'b1;
                mem_req_o.waddr   = word_sel;
                mem_req_o.wdata   = new_word;
                used_d            = used_q - 1'b1;
                avail_d[word_sel] = |(~new_word & mask);
              end
            end
            default: ;
          endcase
        end
      end
      ST_FIND: begin
        found_d         = |avail_q;
        find_word_d     = lowest_word(avail_q);
        mem_req_o.re    = 1'b1;
        mem_req_o.raddr = lowest_word(avail_q);
      end
      ST_RESULT: begin
        if (out_free) begin
          mask                   = word_mask(find_word_q, lim_i);
          out_vld_d              = 1'b1;
          out_d.was_used         = was_q;
          out_d.error_code       = err_q;
          out_d.free_count       = CountW'(lim_i) - used_q;
          out_d.any_free         = found_q;
          out_d.lowest_free_page = found_q ?
              PageW'({find_word_q, lowest_bit(~mem_rdata_i & mask)}) : '0;
        end
      end
      default: ;
    endcase

    // Restart the count and summary over the new limit.
    if (cfg_we_i) begin
      cnt_d      = '0;
      proc_vld_d = 1'b0;
      used_d     = '0;
      avail_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_SWEEP;
      cnt_q      <= '0;
      proc_vld_q <= 1'b0;
      used_q     <= '0;
      avail_q    <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      proc_vld_q <= proc_vld_d;
      used_q     <= used_d;
      avail_q    <= avail_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    proc_word_q <= proc_word_d;
    kind_q      <= kind_d;
    page_q      <= page_d;
    was_q       <= was_d;
    err_q       <= err_d;
    find_word_q <= find_word_d;
    found_q     <= found_d;
    out_q       <= out_d;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

>>> rtl/page_bitmap_allocator_top.sv
// Page bitmap allocator: one used bit per physical page, kept in a
// 32-bit-word bitmap RAM with a per-word "has free page" summary vector.
// Input channel (in_valid_i/in_ready_o/in_data_i): one transfer per request,
// kind = query, mark used or mark free, plus the page number.
// Output channel (out_valid_o/out_ready_i/out_data_o): one transfer per
// request with the old mark, an error code, the free count below the limit
// and the lowest free page.
// Timing: the word read runs in the cycle of the input transfer, then come
// read-modify-write, summary search plus word read, and bit search, so the
// result of the bit search is registered before out_valid_o rises.
// The block takes no new request before the last one is through; in_ready_o is
// high only between requests.
// The result sits in an output register; a stalled receiver holds it, and a
// finished request waits in its last step until that register frees up.
// Configuration: APB register 0 (byte address 0) holds pages_in_use_range.
// Reset and every write of it start a sweep that recounts used pages and
// rebuilds the summary; requests are held off during the sweep. Reset leaves
// every page free.
module page_bitmap_allocator_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  pba_pkg::pba_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output pba_pkg::pba_out_t             out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pba_pkg::AddrW-1:0]     paddr,
  input  logic [pba_pkg::DataW-1:0]     pwdata,
  output logic [pba_pkg::DataW-1:0]     prdata,
  output logic                          pready
);
  import pba_pkg::*;

  logic [RangeW-1:0] range_q;
  logic [RangeW-1:0] lim_eff;
  logic              cfg_we;
  logic              reg_sel;
  pba_mem_req_t      mem_req;
  logic [WordW-1:0]  mem_rdata;

  // Decode register 0 by word address; byte offset bits are ignored.
  assign reg_sel = (paddr[AddrW-1:2] == '0);
  assign cfg_we  = psel && penable && pwrite && reg_sel;
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? DataW'(range_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_q <= RangeReset;
    end else if (cfg_we) begin
      range_q <= pwdata[RangeW-1:0];
    end
  end

  // Clamp the limit to the bitmap size.
  assign lim_eff = (32'(range_q) > MaxPages) ? RangeW'(MaxPages) : range_q;

  pba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .lim_i       (lim_eff),
    .cfg_we_i    (cfg_we),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  pba_bitmap_ram u_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

`ifndef SYNTHESIS
  a_free_le_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.free_count <= CountW'(lim_eff)))
    else $error("free count exceeds page limit");

  a_any_free_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.any_free == (out_data_o.free_count != '0)))
    else $error("any_free disagrees with free count");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request taken while another is in flight");

  a_range_no_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.error_code == ErrRange)) |-> !out_data_o.was_used)
    else $error("out-of-range result reports a used mark");
`endif

endmodule

>>> verif/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pba_pkg::*;

  // Kind 3 has no meaning of its own; the block treats it as a query.
  localparam logic [1:0] KindSpare = 2'd3;
  // Register 0 sits at byte address 0.
  localparam logic [AddrW-1:0] RegPagesInUse = '0;

  // Leave a margin before a register write.
  localparam int SettleCycles   = 8;
  // Long enough for the block to fill its result slot and stall its input.
  localparam int LongHoldCycles = 120;
  // Slowest correct run is roughly 1300 requests plus a sweep per register
  // write and the long hold-offs.
  localparam int CycleLimit     = 200000;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  pba_in_t              in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  pba_out_t             out_data_o;
  logic                 psel        = 1'b0;
  logic                 penable     = 1'b0;
  logic                 pwrite      = 1'b0;
  logic [AddrW-1:0]     paddr       = '0;
  logic [DataW-1:0]     pwdata      = '0;
  logic [DataW-1:0]     prdata;
  logic                 pready;

  // Shadow of the allocator: one used flag per page plus the range register.
  logic [MaxPages-1:0]  page_used;
  logic [RangeW-1:0]    range_reg;
  pba_out_t             pending_results[$];
  pba_out_t             want_result;

  int unsigned          mismatches  = 0;
  int unsigned          cycle_count = 0;
  // Random idling on both sides; cleared for the last part of the run.
  bit                   idle_en     = 1'b1;
  // Bump to ask the receiver for one long hold-off.
  int unsigned          hold_ticket = 0;
  int unsigned          hold_seen   = 0;
  int unsigned          stall_left  = 0;

  page_bitmap_allocator_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #10 clk_i = ~clk_i;

  // Abort a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Pages that exist: the register, saturated to the store size.
  function automatic int unsigned active_limit();
    return (range_reg > MaxPages) ? MaxPages : int'(range_reg);
  endfunction

  // Apply one request to the shadow bitmap and build the result it gives.
  function automatic pba_out_t predict_alloc(pba_in_t req);
    pba_out_t    r;
    int unsigned lim;
    bit          found;
    r     = '0;
    found = 1'b0;
    lim   = active_limit();
    // Out of range wins over every other check and leaves the old mark at 0.
    if (req.page_index >= lim) begin
      r.error_code = ErrRange;
    end else begin
      r.was_used = page_used[req.page_index];
      case (req.kind)
        KindMark: begin
          if (r.was_used) r.error_code = ErrUsed;
          else page_used[req.page_index] = 1'b1;
        end
        KindFree: begin
          if (!r.was_used) r.error_code = ErrFree;
          else page_used[req.page_index] = 1'b0;
        end
        default: ;
      endcase
    end
    // Count and search only below the limit; marks above it stay stored.
    for (int unsigned i = 0; i < lim; i++) begin
      if (!page_used[i]) begin
        r.free_count = r.free_count + 1'b1;
        if (!found) begin
          found              = 1'b1;
          r.lowest_free_page = PageW'(i);
        end
      end
    end
    r.any_free = found;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("ERROR at %0t ns: %s got %0d want %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Receiver: random stall bursts, plus one long hold-off when asked.
  always @(posedge clk_i) begin
    if (hold_ticket != hold_seen) begin
      hold_seen  = hold_ticket;
      stall_left = LongHoldCycles;
    end else if (stall_left == 0 && idle_en && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 7);
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Check each result transfer against the oldest pending prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", 1, 0);
      end else begin
        want_result = pending_results.pop_front();
        if (out_data_o.was_used !== want_result.was_used)
          report_mismatch("was_used", out_data_o.was_used, want_result.was_used);
        if (out_data_o.error_code !== want_result.error_code)
          report_mismatch("error_code", out_data_o.error_code, want_result.error_code);
        if (out_data_o.free_count !== want_result.free_count)
          report_mismatch("free_count", out_data_o.free_count, want_result.free_count);
        if (out_data_o.any_free !== want_result.any_free)
          report_mismatch("any_free", out_data_o.any_free, want_result.any_free);
        if (out_data_o.lowest_free_page !== want_result.lowest_free_page)
          report_mismatch("lowest_free_page", out_data_o.lowest_free_page,
                          want_result.lowest_free_page);
      end
    end
  end

  // Offer one request and hold it until its transfer. Valid stays high after
  // the transfer so that back-to-back requests never lower and raise it in
  // one step; callers that wait for anything else go through drain_results.
  task automatic send_req(logic [1:0] kind, logic [PageW-1:0] page);
    pba_in_t req;
    req.kind       = kind;
    req.page_index = page;
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(predict_alloc(req));
  endtask

  // Mostly in-range pages with a bias toward the low end, so marks and frees
  // collide and the lowest free page moves; some pages anywhere in 0..1023.
  task automatic send_random_req();
    logic [1:0]       kind;
    logic [PageW-1:0] page;
    int unsigned      lim;
    int unsigned      roll;
    lim  = active_limit();
    roll = $urandom_range(0, 99);
    if (roll < 45) kind = KindMark;
    else if (roll < 80) kind = KindFree;
    else if (roll < 95) kind = KindQuery;
    else kind = KindSpare;
    roll = $urandom_range(0, 3);
    if (lim == 0 || roll == 0) page = PageW'($urandom_range(0, MaxPages - 1));
    else if (roll == 1) page = PageW'($urandom_range(0, (lim < 64 ? lim : 64) - 1));
    else page = PageW'($urandom_range(0, lim - 1));
    send_req(kind, page);
  endtask

  // Drop valid and wait until every result is in and the block has settled.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Write the page limit over the register port, only with the block idle.
  task automatic write_page_limit(logic [RangeW-1:0] value);
    drain_results();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= RegPagesInUse;
    pwdata  <= DataW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    range_reg = value;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Every kind on page 0, query, mark and free on page 1023, and the used and free errors at the reset limit.
  task automatic test_basic_ops();
    send_req(KindQuery, 10'd0);
    send_req(KindQuery, 10'd1023);
    send_req(KindMark,  10'd0);
    send_req(KindMark,  10'd0);
    send_req(KindSpare, 10'd0);
    send_req(KindMark,  10'd1023);
    send_req(KindFree,  10'd0);
    send_req(KindFree,  10'd0);
    send_req(KindFree,  10'd1023);
    send_req(KindMark,  10'd1);
  endtask

  // Limit extremes: a single page, no pages, a saturated register, a final
  // partial 32-bit word, and marks kept above a lowered limit.
  task automatic test_limit_edges();
    write_page_limit(11'd1);
    send_req(KindMark,  10'd0);
    send_req(KindQuery, 10'd1);
    send_req(KindMark,  10'd1023);
    send_req(KindFree,  10'd0);
    write_page_limit(11'd0);
    send_req(KindQuery, 10'd0);
    send_req(KindMark,  10'd0);
    write_page_limit(11'd2047);
    send_req(KindMark,  10'd1023);
    send_req(KindFree,  10'd1023);
    write_page_limit(11'd13);
    send_req(KindMark,  10'd12);
    send_req(KindQuery, 10'd13);
    write_page_limit(11'd9);
    send_req(KindQuery, 10'd0);
    write_page_limit(11'd1024);
    send_req(KindQuery, 10'd0);
  endtask

  task automatic test_random_traffic(logic [RangeW-1:0] limit_value, int count);
    write_page_limit(limit_value);
    repeat (count) send_random_req();
  endtask

  // Hold the receiver off for a long stretch while requests keep coming, so
  // the result slot fills and the input stalls.
  task automatic test_backpressure();
    drain_results();
    hold_ticket++;
    repeat (30) send_random_req();
  endtask

  // Pause the sender in the middle of traffic until every result is back.
  task automatic test_sender_pause();
    repeat (30) send_random_req();
    drain_results();
    repeat (30) send_random_req();
  endtask

  initial begin
    page_used = '0;
    range_reg = RangeReset;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_basic_ops();
    test_limit_edges();
    test_random_traffic(11'd1024, 450);
    test_random_traffic(11'd11, 200);
    test_random_traffic(11'd2047, 150);
    test_random_traffic(11'd8, 150);
    write_page_limit(11'd300);
    test_backpressure();
    test_sender_pause();
    // Close out with both sides running flat out.
    idle_en = 1'b0;
    test_random_traffic(11'd1001, 250);

    drain_results();
    repeat (12) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
